[design/tpw_pkg.sv]
`default_nettype none

package tpw_pkg;

  // Window and store geometry
  localparam int WINDOW_POINTS = 64;
  localparam int STORE_DEPTH   = 256;
  localparam int LAG_POINTS    = (3 * WINDOW_POINTS) / 4;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 8;
  localparam int OP_W     = 2;
  localparam int POWER_W  = 33;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int IDX_W    = $clog2(WINDOW_POINTS);
  localparam int WIN_SHIFT = $clog2(WINDOW_POINTS);
  // Width wide enough for position + window + lag and for the store depth
  localparam int CHK_W    = $clog2(STORE_DEPTH + WINDOW_POINTS + LAG_POINTS + 256) + 1;

  // Three phases side by side in one memory word
  localparam int PHASE_W  = 3 * SAMPLE_W;

  // Product, three-phase sum and exact window accumulator widths
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int ACC_W    = SUM_W + IDX_W + 1;

  // Stream widths
  localparam int IN_TDATA_W  = ((POS_W + 6 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((POWER_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_ACTIVE   = 2'd1,
    OP_REACTIVE = 2'd2,
    OP_INVALID  = 2'd3
  } op_t;

  // Control that travels with the memory read data into the datapath
  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

[design/tpw_ram.sv]
`default_nettype none

module tpw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/tpw_mac.sv]
`default_nettype none

module tpw_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tpw_pkg::mac_ctl_t                 ctl,
  input  wire logic [tpw_pkg::PHASE_W-1:0]       volt_word,
  input  wire logic [tpw_pkg::PHASE_W-1:0]       curr_word,
  output      logic signed [tpw_pkg::ACC_W-1:0]  acc,
  output      logic                              done
);

  localparam int SW = tpw_pkg::SAMPLE_W;

  logic signed [SW-1:0] va, vb, vc, ia, ib, ic;
  logic signed [tpw_pkg::PROD_W-1:0] pa_r, pb_r, pc_r;
  logic signed [tpw_pkg::SUM_W-1:0]  sum_r;
  logic signed [tpw_pkg::ACC_W-1:0]  acc_r;
  logic p_valid_r, p_last_r, s_valid_r, s_last_r, done_r;

  // Split the memory words into phase samples
  assign va = volt_word[SW-1:0];
  assign vb = volt_word[2*SW-1:SW];
  assign vc = volt_word[3*SW-1:2*SW];
  assign ia = curr_word[SW-1:0];
  assign ib = curr_word[2*SW-1:SW];
  assign ic = curr_word[3*SW-1:2*SW];

  // Advance the valid and last markers along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      p_last_r  <= 1'b0;
      s_valid_r <= 1'b0;
      s_last_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      p_valid_r <= ctl.valid;
      p_last_r  <= ctl.valid & ctl.last;
      s_valid_r <= p_valid_r;
      s_last_r  <= p_last_r;
      done_r    <= s_valid_r & s_last_r;
    end
  end

  // Multiply per phase, add the phases, accumulate the window
  always_ff @(posedge clk) begin
    pa_r  <= va * ia;
    pb_r  <= vb * ib;
    pc_r  <= vc * ic;
    sum_r <= tpw_pkg::SUM_W'(pa_r) + tpw_pkg::SUM_W'(pb_r) + tpw_pkg::SUM_W'(pc_r);
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (s_valid_r) begin
      acc_r <= acc_r + tpw_pkg::ACC_W'(sum_r);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

[design/three_phase_power_window.sv]
`default_nettype none

// Three-phase windowed power over a sample store.
// Input channel in_*: in_tuser carries the operation, in_tdata the position and
// the six phase samples. Output channel out_*: one result per item, out_tdata
// carries the power value, out_tuser the window error flag.
// A write item stores one time index of all six samples and returns 0 in the
// cycle after it is accepted. An invalid operation or a window that runs past
// the store also returns at once, with the error flag set.
// An active or reactive power item sweeps the window through the two sample
// memories, one time index per cycle; its result passes through the start
// state, the window reads, the memory read, the multiply, phase-sum and
// accumulate stages, the finish state and the output register.
// One item is worked on at a time; the next item is taken once the sequencer
// is idle and the output register is empty or read in that same cycle.
// When the receiver stalls, the result holds in the output register, the input
// stalls, and a finished window waits for the register to free before it loads.
// Reset clears the sequencer and the output valid; the sample memories keep
// their contents and are undefined until written.
module three_phase_power_window (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // position[7:0], volt_a, curr_a, volt_b, curr_b, volt_c, curr_c
  input  wire logic [tpw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation[1:0]
  input  wire logic [tpw_pkg::OP_W-1:0]          in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // power_value[32:0], zero fill above
  output      logic [tpw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // window_error
  output      logic                              out_tuser
);

  localparam int SW  = tpw_pkg::SAMPLE_W;
  localparam int PW  = tpw_pkg::POS_W;
  localparam int CW  = tpw_pkg::CHK_W;
  localparam int AW  = tpw_pkg::ADDR_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  tpw_pkg::op_t          in_op;
  logic [PW-1:0]         in_pos;
  logic [tpw_pkg::PHASE_W-1:0] in_volt, in_curr;
  logic                  accept, is_compute, is_reactive, range_err, write_ok;
  logic [CW-1:0]         win_end;

  logic [PW-1:0]         pos_r;
  logic                  lag_r;
  logic [tpw_pkg::IDX_W-1:0] idx_r;
  logic                  idx_last;
  logic [CW-1:0]         v_addr_full, c_addr_full;
  logic [AW-1:0]         v_addr, c_addr;
  logic                  rd_en, rd_valid_r, rd_last_r;

  logic [tpw_pkg::PHASE_W-1:0] volt_rdata, curr_rdata;
  tpw_pkg::mac_ctl_t     mac_ctl;
  logic signed [tpw_pkg::ACC_W-1:0] acc;
  logic signed [tpw_pkg::ACC_W-1:0] acc_shift;
  logic                  mac_done;

  logic                  out_free, load_now, load_fin;
  logic                  out_valid_r, out_err_r;
  logic [tpw_pkg::POWER_W-1:0] out_power_r;

  // Unpack the input item
  assign in_op   = tpw_pkg::op_t'(in_tuser);
  assign in_pos  = in_tdata[PW-1:0];
  assign in_volt = {in_tdata[PW+5*SW-1:PW+4*SW], in_tdata[PW+3*SW-1:PW+2*SW],
                    in_tdata[PW+SW-1:PW]};
  assign in_curr = {in_tdata[PW+6*SW-1:PW+5*SW], in_tdata[PW+4*SW-1:PW+3*SW],
                    in_tdata[PW+2*SW-1:PW+SW]};

  assign accept      = in_tvalid & in_tready;
  assign is_reactive = (in_op == tpw_pkg::OP_REACTIVE);
  assign is_compute  = (in_op == tpw_pkg::OP_ACTIVE) | is_reactive;

  // Check that the window, with its lag, stays inside the store
  assign win_end   = CW'(in_pos) + CW'(tpw_pkg::WINDOW_POINTS) +
                     (is_reactive ? CW'(tpw_pkg::LAG_POINTS) : CW'(0));
  assign range_err = win_end > CW'(tpw_pkg::STORE_DEPTH);
  assign write_ok  = CW'(in_pos) < CW'(tpw_pkg::STORE_DEPTH);

  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (state_r == ST_IDLE) & out_free;

  // Sequence one window
  assign idx_last = (idx_r == tpw_pkg::IDX_W'(tpw_pkg::WINDOW_POINTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_compute && !range_err) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (idx_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      rd_valid_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      rd_last_r  <= rd_en & idx_last;
      if (accept) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Hold the window start and lag select
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= in_pos;
      lag_r <= is_reactive;
    end
  end

  // Form the read addresses: current lags voltage on reactive power
  assign rd_en       = (state_r == ST_RUN);
  assign v_addr_full = CW'(pos_r) + CW'(idx_r);
  assign c_addr_full = v_addr_full + (lag_r ? CW'(tpw_pkg::LAG_POINTS) : CW'(0));
  assign v_addr      = v_addr_full[AW-1:0];
  assign c_addr      = c_addr_full[AW-1:0];

  tpw_ram #(
    .WIDTH (tpw_pkg::PHASE_W),
    .DEPTH (tpw_pkg::STORE_DEPTH)
  ) u_volt_ram (
    .clk   (clk),
    .we    (accept & (in_op == tpw_pkg::OP_WRITE) & write_ok),
    .waddr (in_pos[AW-1:0]),
    .wdata (in_volt),
    .re    (rd_en),
    .raddr (v_addr),
    .rdata (volt_rdata)
  );

  tpw_ram #(
    .WIDTH (tpw_pkg::PHASE_W),
    .DEPTH (tpw_pkg::STORE_DEPTH)
  ) u_curr_ram (
    .clk   (clk),
    .we    (accept & (in_op == tpw_pkg::OP_WRITE) & write_ok),
    .waddr (in_pos[AW-1:0]),
    .wdata (in_curr),
    .re    (rd_en),
    .raddr (c_addr),
    .rdata (curr_rdata)
  );

  assign mac_ctl.clear = accept;
  assign mac_ctl.valid = rd_valid_r;
  assign mac_ctl.last  = rd_last_r;

  tpw_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .volt_word (volt_rdata),
    .curr_word (curr_rdata),
    .acc       (acc),
    .done      (mac_done)
  );

  // Divide by the window with a flooring shift
  assign acc_shift = acc >>> tpw_pkg::WIN_SHIFT;

  // Load the output register: immediate results on accept, window at the end
  assign load_now = accept & ~(is_compute & ~range_err);
  assign load_fin = (state_r == ST_FIN) & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_now || load_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      out_power_r <= '0;
      out_err_r   <= (in_op != tpw_pkg::OP_WRITE);
    end else if (load_fin) begin
      out_power_r <= acc_shift[tpw_pkg::POWER_W-1:0];
      out_err_r   <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tpw_pkg::OUT_TDATA_W - tpw_pkg::POWER_W){1'b0}}, out_power_r};
  assign out_tuser  = out_err_r;

endmodule

`default_nettype wire
